// ===== rtl/orbit_camera_position_core_macros.svh =====
// orbit_camera_position_core_macros.svh: assertion macros for the orbit camera core.
// Depends on nothing; included by the top level, which holds the assertions.
`ifndef ORBIT_CAMERA_POSITION_CORE_MACROS_SVH
`define ORBIT_CAMERA_POSITION_CORE_MACROS_SVH

// Condition in this cycle implies the property in the same cycle.
`define OCP_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition in this cycle implies the property in the next cycle.
`define OCP_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/ocp_pkg.sv =====
// ocp_pkg: widths, constants, types and the arctangent table of the orbit camera core.
// Used by the CORDIC cell, the CORDIC row and the top level; depends on nothing.
package ocp_pkg;

    localparam int ANGLE_W    = 18;
    localparam int XY_W       = 32;
    localparam int Z_W        = 26;
    localparam int POS_W      = 25;
    localparam int ZOOM_W     = 16;
    localparam int YAW_W      = 17;
    localparam int PITCH_W    = 16;
    localparam int MOVE_W     = 16;
    localparam int DIR_W      = 2;
    localparam int RADIUS_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int TURN_W     = MOVE_W + GAIN_W + 1;
    localparam int ACC_W      = 25;
    localparam int PROD_W     = 2 * XY_W;
    localparam int RND_W      = PROD_W - 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ATAN_DEPTH = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ORBIT_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_YAW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PITCH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ZOOM   = 3'd5;

    localparam logic CMD_MOTION = 1'b0;
    localparam logic CMD_SCROLL = 1'b1;
    localparam logic TAG_PITCH  = 1'b0;
    localparam logic TAG_YAW    = 1'b1;

    localparam logic signed [ANGLE_W-1:0] FULL_TURN_A     = 18'sd92160;
    localparam logic signed [ANGLE_W-1:0] HALF_TURN_A     = 18'sd46080;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN_A  = 18'sd23040;
    localparam logic signed [ANGLE_W-1:0] THREE_QUARTER_A = 18'sd69120;

    localparam logic [YAW_W-1:0]  YAW_TURN  = 17'd92160;
    localparam logic [ACC_W-1:0]  WRAP_TURN = 25'd92160;
    localparam logic [ACC_W-1:0]  WRAP_BIAS = 25'd8478720;

    localparam logic signed [PITCH_W-1:0] PITCH_LIMIT   = 16'sd22784;
    localparam logic signed [ACC_W-1:0]   PITCH_LIMIT_W = 25'sd22784;

    localparam logic signed [XY_W-1:0]  CORDIC_START = 32'sd652032874;
    localparam logic signed [RND_W-1:0] POS_MAX_W    = 34'sd16777215;
    localparam logic signed [POS_W-1:0] POS_MAX      = 25'sd16777215;
    localparam logic [ZOOM_W-1:0]       ZOOM_MAX     = 16'hFFFF;

    localparam logic signed [Z_W-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_TURN,
        S_ADD,
        S_WRAP,
        S_TRIG,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                   vld;
        logic                   tag;
        logic                   flip;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic_pkt;

    typedef struct packed {
        logic                   vld;
        logic                   tag;
        logic signed [XY_W-1:0] cos_v;
        logic signed [XY_W-1:0] sin_v;
    } t_trig_res;

endpackage

// ===== rtl/ocp_cordic_cell.sv =====
// ocp_cordic_cell: one registered rotation step of the CORDIC row.
// Depends on ocp_pkg for the packet type and the arctangent table.
module ocp_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ocp_pkg::t_cordic_pkt i_pkt,
    output ocp_pkg::t_cordic_pkt o_pkt
);
    import ocp_pkg::*;

    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;
    logic signed [Z_W-1:0]  w_da;
    logic                   r_vld;
    logic                   r_tag;
    logic                   r_flip;
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;

    assign w_dx = i_pkt.y >>> STEP;
    assign w_dy = i_pkt.x >>> STEP;
    assign w_da = ATAN_TABLE[STEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_pkt.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= i_pkt.tag;
        r_flip <= i_pkt.flip;
        if (!i_pkt.z[Z_W-1]) begin
            r_x <= i_pkt.x - w_dx;
            r_y <= i_pkt.y + w_dy;
            r_z <= i_pkt.z - w_da;
        end else begin
            r_x <= i_pkt.x + w_dx;
            r_y <= i_pkt.y - w_dy;
            r_z <= i_pkt.z + w_da;
        end
    end

    always_comb begin
        o_pkt      = '0;
        o_pkt.vld  = r_vld;
        o_pkt.tag  = r_tag;
        o_pkt.flip = r_flip;
        o_pkt.x    = r_x;
        o_pkt.y    = r_y;
        o_pkt.z    = r_z;
    end

endmodule

// ===== rtl/ocp_cordic_row.sv =====
// ocp_cordic_row: quadrant folding stage followed by a chain of CORDIC cells.
// Depends on ocp_pkg and ocp_cordic_cell.
module ocp_cordic_row #(
    parameter int TRIG_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic                                 i_tag,
    input  logic signed [ocp_pkg::ANGLE_W-1:0]   i_angle,
    output ocp_pkg::t_trig_res                   o_res
);
    import ocp_pkg::*;

    logic signed [ANGLE_W-1:0] w_red;
    logic                      w_flip;
    logic                      r_vld;
    logic                      r_tag;
    logic                      r_flip;
    logic signed [Z_W-1:0]     r_z;
    t_cordic_pkt               w_pkt [TRIG_STEPS+1];

    always_comb begin
        w_red  = i_angle;
        w_flip = 1'b0;
        if (i_angle > THREE_QUARTER_A) begin
            w_red = i_angle - FULL_TURN_A;
        end else if (i_angle > QUARTER_TURN_A) begin
            w_red  = i_angle - HALF_TURN_A;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= i_tag;
        r_flip <= w_flip;
        r_z    <= {w_red, 8'd0};
    end

    always_comb begin
        w_pkt[0]      = '0;
        w_pkt[0].vld  = r_vld;
        w_pkt[0].tag  = r_tag;
        w_pkt[0].flip = r_flip;
        w_pkt[0].x    = CORDIC_START;
        w_pkt[0].y    = '0;
        w_pkt[0].z    = r_z;
    end

    for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_cell
        ocp_cordic_cell #(
            .STEP(k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_pkt  (w_pkt[k]),
            .o_pkt  (w_pkt[k+1])
        );
    end

    always_comb begin
        o_res       = '0;
        o_res.vld   = w_pkt[TRIG_STEPS].vld;
        o_res.tag   = w_pkt[TRIG_STEPS].tag;
        o_res.cos_v = w_pkt[TRIG_STEPS].flip ? -w_pkt[TRIG_STEPS].x : w_pkt[TRIG_STEPS].x;
        o_res.sin_v = w_pkt[TRIG_STEPS].flip ? -w_pkt[TRIG_STEPS].y : w_pkt[TRIG_STEPS].y;
    end

endmodule

// ===== rtl/orbit_camera_position_core.sv =====
// Motion transaction: runs the eight-step yaw wrap, the CORDIC row of TRIG_STEPS cells and
// the shared 32 x 32 multiplier (five products) in turn; a new one is taken only after the
// result is loaded into the output register, which can wait on an output stall.
// Scroll transaction: straight to the output register, or via the trig path when first.
// Synchronous active-low reset clears control and position and loads default configuration;
// the first transaction after reset loads yaw, pitch and zoom from the start registers.
`include "orbit_camera_position_core_macros.svh"

module orbit_camera_position_core #(
    parameter int TRIG_STEPS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ocp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ocp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_cmd,
    input  logic signed [ocp_pkg::MOVE_W-1:0]     i_move_x,
    input  logic signed [ocp_pkg::MOVE_W-1:0]     i_move_y,
    input  logic signed [ocp_pkg::DIR_W-1:0]      i_scroll_dir,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ocp_pkg::POS_W-1:0]      o_pos_x,
    output logic signed [ocp_pkg::POS_W-1:0]      o_pos_y,
    output logic signed [ocp_pkg::POS_W-1:0]      o_pos_z,
    output logic [ocp_pkg::ZOOM_W-1:0]            o_field_of_view
);
    import ocp_pkg::*;

    localparam logic [2:0] WRAP_TOP  = 3'd7;
    localparam logic [1:0] FEED_DONE = 2'd2;
    localparam logic [2:0] MUL_CPCY  = 3'd0;
    localparam logic [2:0] MUL_CPSY  = 3'd1;
    localparam logic [2:0] MUL_RSP   = 3'd2;
    localparam logic [2:0] MUL_RF0   = 3'd3;
    localparam logic [2:0] MUL_RF1   = 3'd4;
    localparam logic [2:0] MUL_LAST  = 3'd5;

    t_state r_state;
    t_state n_state;

    logic [RADIUS_W-1:0]       r_orbit_radius;
    logic [GAIN_W-1:0]         r_turn_gain;
    logic [ZOOM_W-1:0]         r_zoom_step;
    logic [YAW_W-1:0]          r_start_yaw;
    logic signed [PITCH_W-1:0] r_start_pitch;
    logic [ZOOM_W-1:0]         r_start_zoom;

    logic                      r_started;
    logic [YAW_W-1:0]          r_yaw;
    logic signed [PITCH_W-1:0] r_pitch;
    logic [ZOOM_W-1:0]         r_zoom;
    logic signed [MOVE_W-1:0]  r_mx;
    logic signed [MOVE_W-1:0]  r_my;
    logic signed [TURN_W-1:0]  r_tx;
    logic signed [TURN_W-1:0]  r_ty;
    logic [ACC_W-1:0]          r_acc;
    logic [2:0]                r_wstep;
    logic [1:0]                r_feed;
    logic [2:0]                r_mstep;
    logic signed [XY_W-1:0]    r_cp;
    logic signed [XY_W-1:0]    r_sp;
    logic signed [XY_W-1:0]    r_cy;
    logic signed [XY_W-1:0]    r_sy;
    logic signed [XY_W-1:0]    r_f0;
    logic signed [XY_W-1:0]    r_f1;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [POS_W-1:0]   r_pos_x;
    logic signed [POS_W-1:0]   r_pos_y;
    logic signed [POS_W-1:0]   r_pos_z;
    logic                      r_out_vld;
    logic signed [POS_W-1:0]   r_out_x;
    logic signed [POS_W-1:0]   r_out_y;
    logic signed [POS_W-1:0]   r_out_z;
    logic [ZOOM_W-1:0]         r_out_zoom;

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_out_load;
    logic                      w_trig_vld;
    logic signed [ANGLE_W-1:0] w_trig_angle;
    t_trig_res                 w_trig;
    logic [YAW_W-1:0]          w_start_yaw_mod;
    logic signed [PITCH_W-1:0] w_start_pitch_cl;
    logic [YAW_W-1:0]          w_yaw_base;
    logic signed [PITCH_W-1:0] w_pitch_base;
    logic [ZOOM_W-1:0]         w_zoom_base;
    logic [ZOOM_W:0]           w_zoom_dn;
    logic [ZOOM_W:0]           w_zoom_up;
    logic [ZOOM_W-1:0]         w_zoom_next;
    logic signed [TURN_W-1:0]  w_tx_rnd;
    logic signed [TURN_W-1:0]  w_ty_rnd;
    logic signed [ACC_W-1:0]   w_dx;
    logic signed [ACC_W-1:0]   w_dy;
    logic [ACC_W-1:0]          w_acc_start;
    logic signed [ACC_W-1:0]   w_pitch_diff;
    logic signed [PITCH_W-1:0] w_pitch_new;
    logic [ACC_W-1:0]          w_wrap_const;
    logic [ACC_W-1:0]          w_acc_next;
    logic signed [XY_W-1:0]    w_radius;
    logic signed [XY_W-1:0]    w_mul_a;
    logic signed [XY_W-1:0]    w_mul_b;
    logic signed [PROD_W-1:0]  w_rnd_full;
    logic signed [RND_W-1:0]   w_rnd;
    logic signed [XY_W-1:0]    w_fac;
    logic signed [POS_W-1:0]   w_sat;

    // Control outputs of the sequencer.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_accept   = i_in_valid && (r_state == S_IDLE);
        w_out_free = !r_out_vld || !i_out_stall;
        w_out_load = (r_state == S_DONE) && w_out_free;
        w_trig_vld = (r_state == S_TRIG) && (r_feed != FEED_DONE);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_MOTION) begin
                        n_state = S_TURN;
                    end else if (r_started) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_TRIG;
                    end
                end
            end
            S_TURN: n_state = S_ADD;
            S_ADD:  n_state = S_WRAP;
            S_WRAP: begin
                if (r_wstep == '0) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG: begin
                if (w_trig.vld && (w_trig.tag == TAG_YAW)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_mstep == MUL_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Start values, pitch clamp and zoom update.
    always_comb begin
        w_start_yaw_mod  = (r_start_yaw >= YAW_TURN) ? r_start_yaw - YAW_TURN : r_start_yaw;
        w_start_pitch_cl = r_start_pitch;
        if (r_start_pitch > PITCH_LIMIT) begin
            w_start_pitch_cl = PITCH_LIMIT;
        end else if (r_start_pitch < -PITCH_LIMIT) begin
            w_start_pitch_cl = -PITCH_LIMIT;
        end
        w_yaw_base   = r_started ? r_yaw : w_start_yaw_mod;
        w_pitch_base = r_started ? r_pitch : w_start_pitch_cl;
        w_zoom_base  = r_started ? r_zoom : r_start_zoom;
        w_zoom_dn    = {1'b0, w_zoom_base} - {1'b0, r_zoom_step};
        w_zoom_up    = {1'b0, w_zoom_base} + {1'b0, r_zoom_step};
        w_zoom_next  = w_zoom_base;
        if (i_cmd == CMD_SCROLL) begin
            if (i_scroll_dir == 2'sd1) begin
                w_zoom_next = w_zoom_dn[ZOOM_W] ? '0 : w_zoom_dn[ZOOM_W-1:0];
            end else if (i_scroll_dir[DIR_W-1]) begin
                w_zoom_next = w_zoom_up[ZOOM_W] ? ZOOM_MAX : w_zoom_up[ZOOM_W-1:0];
            end
        end
    end

    // Turn deltas, biased yaw sum, clamped pitch update and one restoring step of the yaw wrap.
    always_comb begin
        w_tx_rnd     = (r_tx + 33'sd128) >>> 8;
        w_ty_rnd     = (r_ty + 33'sd128) >>> 8;
        w_dx         = w_tx_rnd[ACC_W-1:0];
        w_dy         = w_ty_rnd[ACC_W-1:0];
        w_acc_start  = {8'd0, r_yaw} + $unsigned(w_dx) + WRAP_BIAS;
        w_pitch_diff = {{(ACC_W-PITCH_W){r_pitch[PITCH_W-1]}}, r_pitch} - w_dy;
        w_pitch_new  = w_pitch_diff[PITCH_W-1:0];
        if (w_pitch_diff > PITCH_LIMIT_W) begin
            w_pitch_new = PITCH_LIMIT;
        end else if (w_pitch_diff < -PITCH_LIMIT_W) begin
            w_pitch_new = -PITCH_LIMIT;
        end
        w_wrap_const = WRAP_TURN << r_wstep;
        w_acc_next   = (r_acc >= w_wrap_const) ? r_acc - w_wrap_const : r_acc;
    end

    assign w_trig_angle = (r_feed[0] == TAG_YAW) ? $signed({1'b0, r_yaw})
                                                 : {{(ANGLE_W-PITCH_W){r_pitch[PITCH_W-1]}},
                                                    r_pitch};

    ocp_cordic_row #(
        .TRIG_STEPS(TRIG_STEPS)
    ) u_row (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_trig_vld),
        .i_tag  (r_feed[0]),
        .i_angle(w_trig_angle),
        .o_res  (w_trig)
    );

    // Shared multiplier operands, rounding and saturation of the registered product.
    always_comb begin
        w_radius = $signed({8'd0, r_orbit_radius});
        case (r_mstep)
            MUL_CPCY: begin
                w_mul_a = r_cp;
                w_mul_b = r_cy;
            end
            MUL_CPSY: begin
                w_mul_a = r_cp;
                w_mul_b = r_sy;
            end
            MUL_RSP: begin
                w_mul_a = w_radius;
                w_mul_b = r_sp;
            end
            MUL_RF0: begin
                w_mul_a = w_radius;
                w_mul_b = r_f0;
            end
            MUL_RF1: begin
                w_mul_a = w_radius;
                w_mul_b = r_f1;
            end
            default: begin
                w_mul_a = w_radius;
                w_mul_b = r_sp;
            end
        endcase
        w_rnd_full = r_prod + (64'sd1 <<< 29);
        w_rnd      = w_rnd_full[PROD_W-1:30];
        w_fac      = w_rnd[XY_W-1:0];
        w_sat      = w_rnd[POS_W-1:0];
        if (w_rnd > POS_MAX_W) begin
            w_sat = POS_MAX;
        end else if (w_rnd < -POS_MAX_W) begin
            w_sat = -POS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_started      <= 1'b0;
            r_wstep        <= '0;
            r_feed         <= '0;
            r_mstep        <= '0;
            r_out_vld      <= 1'b0;
            r_pos_x        <= '0;
            r_pos_y        <= '0;
            r_pos_z        <= '0;
            r_orbit_radius <= 24'd2560;
            r_turn_gain    <= 16'd6554;
            r_zoom_step    <= 16'd819;
            r_start_yaw    <= 17'd0;
            r_start_pitch  <= 16'sd0;
            r_start_zoom   <= 16'd12868;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_started <= 1'b1;
            end
            if (r_state == S_ADD) begin
                r_wstep <= WRAP_TOP;
            end else if ((r_state == S_WRAP) && (r_wstep != '0)) begin
                r_wstep <= r_wstep - 3'd1;
            end
            if (r_state != S_TRIG) begin
                r_feed <= '0;
            end else if (r_feed != FEED_DONE) begin
                r_feed <= r_feed + 2'd1;
            end
            if (r_state != S_MUL) begin
                r_mstep <= '0;
            end else begin
                r_mstep <= r_mstep + 3'd1;
                case (r_mstep)
                    MUL_RF0:  r_pos_y <= w_sat;
                    MUL_RF1:  r_pos_x <= w_sat;
                    MUL_LAST: r_pos_z <= w_sat;
                    default:  ;
                endcase
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ORBIT_RADIUS: r_orbit_radius <= i_cfg_data[RADIUS_W-1:0];
                    CFG_TURN_GAIN:    r_turn_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_ZOOM_STEP:    r_zoom_step    <= i_cfg_data[ZOOM_W-1:0];
                    CFG_START_YAW:    r_start_yaw    <= i_cfg_data[YAW_W-1:0];
                    CFG_START_PITCH:  r_start_pitch  <= $signed(i_cfg_data[PITCH_W-1:0]);
                    CFG_START_ZOOM:   r_start_zoom   <= i_cfg_data[ZOOM_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_yaw   <= w_yaw_base;
            r_pitch <= w_pitch_base;
            r_zoom  <= w_zoom_next;
            r_mx    <= i_move_x;
            r_my    <= i_move_y;
        end
        if (r_state == S_TURN) begin
            r_tx <= r_mx * $signed({1'b0, r_turn_gain});
            r_ty <= r_my * $signed({1'b0, r_turn_gain});
        end
        if (r_state == S_ADD) begin
            r_acc   <= w_acc_start;
            r_pitch <= w_pitch_new;
        end
        if (r_state == S_WRAP) begin
            r_acc <= w_acc_next;
            if (r_wstep == '0) begin
                r_yaw <= w_acc_next[YAW_W-1:0];
            end
        end
        if (w_trig.vld) begin
            if (w_trig.tag == TAG_YAW) begin
                r_cy <= w_trig.cos_v;
                r_sy <= w_trig.sin_v;
            end else begin
                r_cp <= w_trig.cos_v;
                r_sp <= w_trig.sin_v;
            end
        end
        r_prod <= w_mul_a * w_mul_b;
        if (r_state == S_MUL) begin
            case (r_mstep)
                MUL_CPSY: r_f0 <= w_fac;
                MUL_RSP:  r_f1 <= w_fac;
                default:  ;
            endcase
        end
        if (w_out_load) begin
            r_out_x    <= r_pos_x;
            r_out_y    <= r_pos_y;
            r_out_z    <= r_pos_z;
            r_out_zoom <= r_zoom;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_pos_x         = r_out_x;
    assign o_pos_y         = r_out_y;
    assign o_pos_z         = r_out_z;
    assign o_field_of_view = r_out_zoom;

    `OCP_ASSERT_IMP(a_yaw_wrapped, i_clk, i_rst_n, (r_state == S_TRIG), (r_yaw < YAW_TURN), "yaw out of range after the wrap")
    `OCP_ASSERT_IMP(a_pitch_clamped, i_clk, i_rst_n, (r_state == S_TRIG), ((r_pitch <= PITCH_LIMIT) && (r_pitch >= -PITCH_LIMIT)), "pitch beyond its limit")
    `OCP_ASSERT_IMP(a_trig_owned, i_clk, i_rst_n, w_trig.vld, (r_state == S_TRIG), "trig result outside the trig phase")
    `OCP_ASSERT_NXT(a_out_loaded, i_clk, i_rst_n, w_out_load, (o_out_valid && (r_state == S_IDLE)), "result not presented after completion")

endmodule
